>>> rtl/core/fas_pkg.sv
package fas_pkg;
  localparam int FracBits = 23;
  localparam int ExpBits  = 8;
  localparam int SigBits  = FracBits + 1;
  localparam int SumBits  = SigBits + 1;
  localparam int ExpWide  = ExpBits + 2;

  typedef struct packed {
    logic                 sign;
    logic [ExpWide-1:0]   expo;
    logic [SumBits-1:0]   mag;
    logic                 zero;
  } fas_mid_t;
endpackage

>>> rtl/core/float32_add_sub_truncating.sv
// single-precision add/subtract, truncating, no rounding or special values
// input channel: in_valid/in_ready with kind, operand_a, operand_b
//   kind 0 adds, kind 1 subtracts operand_b from operand_a
// output channel: out_valid/out_ready with sum_word and range_error
//   range_error flags a result exponent outside 0..255; the field wraps
// two register stages: stage one aligns and adds or subtracts, stage two
//   normalizes and packs; each result is held first in the mid register and
//   then in the sum_word/range_error output register
// throughput is one transfer per cycle; each stage holds when the stage
//   after it is full and not draining, so a stalled receiver backs up the
//   pipe one stage at a time and in_ready drops only when both are full
// exact cancellation gives +0; an emptied difference lowers exponent by 24
// reset clears both stage valid bits; payload registers are not reset
module float32_add_sub_truncating import fas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sum_word,
  output logic        range_error
);

  logic     mid_valid;
  fas_mid_t mid, mid_next;
  logic     mid_ready;

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  // stage one: unpack, align, add or subtract
  logic               sa, sb;
  logic [ExpBits-1:0] ea, eb;
  logic [SigBits-1:0] ma, mb, big_m, sml_m, t_sh;
  logic [ExpBits-1:0] diff;
  logic               b_big, borrow;
  logic [SumBits-1:0] sum_m;

  always_comb begin
    sa = operand_a[31];
    sb = operand_b[31] ^ kind;
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    ma = {1'b1, operand_a[FracBits-1:0]};
    mb = {1'b1, operand_b[FracBits-1:0]};
    b_big = (eb > ea);
    diff  = b_big ? (eb - ea) : (ea - eb);
    big_m = b_big ? mb : ma;
    sml_m = b_big ? ma : mb;
    // shift by diff-1, keep low bit as borrow, then one more
    if (diff == '0) begin
      t_sh = '0;
      borrow = 1'b0;
    end else begin
      if (diff > ExpBits'(SigBits)) t_sh = '0;
      else t_sh = sml_m >> (diff - 1'b1);
      borrow = t_sh[0];
      sml_m  = t_sh >> 1;
    end
    if (b_big) begin
      mb = big_m;
      ma = sml_m;
    end else begin
      ma = big_m;
      mb = sml_m;
    end
    mid_next.expo = {2'b00, (b_big ? eb : ea)};
    mid_next.zero = (operand_a[22:0] == operand_b[22:0]) && (ea == eb) && (sa != sb);
    if (sa == sb) begin
      sum_m = {1'b0, ma} + {1'b0, mb};
      mid_next.sign = sa;
    end else if (ma > mb) begin
      sum_m = {1'b0, ma} - {1'b0, mb} - SumBits'(borrow);
      mid_next.sign = sa;
    end else begin
      sum_m = {1'b0, mb} - {1'b0, ma} - SumBits'(borrow);
      mid_next.sign = sb;
    end
    mid_next.mag = sum_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      mid <= mid_next;
    end
  end

  // stage two: leading-one normalize and pack
  logic [4:0]          lead;
  logic                found;
  logic [SumBits-1:0]  nm;
  logic signed [ExpWide:0] e_n;
  logic [31:0]         word_next;
  logic                err_next;

  always_comb begin
    lead  = '0;
    found = 1'b0;
    for (int i = 0; i < SumBits; i++) begin
      if (mid.mag[i]) begin
        lead  = 5'(i);
        found = 1'b1;
      end
    end
    e_n = $signed({1'b0, mid.expo});
    if (!found) begin
      nm  = '0;
      e_n = e_n - (ExpWide+1)'(SigBits);
    end else if (lead == 5'(SigBits)) begin
      nm  = mid.mag >> 1;
      e_n = e_n + $signed((ExpWide+1)'(1));
    end else begin
      nm  = mid.mag << (5'(FracBits) - lead);
      e_n = e_n - $signed({1'b0, (ExpWide)'(5'(FracBits) - lead)});
    end
    err_next = (e_n < 0) || (e_n > 255);
    word_next = {mid.sign, e_n[ExpBits-1:0], nm[FracBits-1:0]};
    if (mid.zero) begin
      word_next = '0;
      err_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
    if (mid_ready && mid_valid) begin
      sum_word    <= word_next;
      range_error <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    (!mid_valid || !out_valid) |-> in_ready) else $error("in_ready low with room");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && mid_ready) |=> out_valid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(sum_word)) else $error("result changed");
`endif

endmodule
